>>> rtl/wsd_pkg.sv
// Package for the sliding-window sum threshold detector.
// Holds field widths, configuration register indexes and the result word type.
// No dependencies.
package wsd_pkg;

    localparam int DAY_W   = 16;
    localparam int TIME_W  = 17;
    localparam int FCNT_W  = 16;
    localparam int WSUM_W  = 20;
    localparam int WLEN_W  = 5;
    localparam int CFG_W   = 20;
    localparam int IDX_REG_W = 1;

    localparam logic [IDX_REG_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [IDX_REG_W-1:0] REG_THRESHOLD     = 1'b1;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;

    typedef struct packed {
        logic [WSUM_W-1:0] window_sum;
        logic [TIME_W-1:0] window_end;
        logic [TIME_W-1:0] window_start;
        logic [DAY_W-1:0]  window_day;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [DAY_W-1:0]  day_code;
    } tag_t;

endpackage

>>> rtl/wsd_cell.sv
// One cell of the window chain: holds a single snapshot's count, day and start.
// Loads either the incoming snapshot or its upstream neighbor's content.
// Depends on wsd_pkg.
module wsd_cell #(
    parameter int CNT_W = 16
) (
    input  logic                aclk,
    input  logic                load,
    input  logic                sel_new,
    input  logic [CNT_W-1:0]    new_cnt,
    input  wsd_pkg::tag_t       new_tag,
    input  logic [CNT_W-1:0]    nbr_cnt,
    input  wsd_pkg::tag_t       nbr_tag,
    output logic [CNT_W-1:0]    cnt_q,
    output wsd_pkg::tag_t       tag_q,
    output wsd_pkg::tag_t       tag_d
);

    logic [CNT_W-1:0] cnt_reg;
    wsd_pkg::tag_t    tag_reg;
    logic [CNT_W-1:0] cnt_d;

    always_comb begin
        cnt_d = sel_new ? new_cnt : nbr_cnt;
        tag_d = sel_new ? new_tag : nbr_tag;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cnt_reg <= cnt_d;
            tag_reg <= tag_d;
        end
    end

    assign cnt_q = cnt_reg;
    assign tag_q = tag_reg;

endmodule

>>> rtl/wsd_outbuf.sv
// Two-entry output buffer (output register plus skid register) for result words.
// Keeps the input side free while one result waits downstream.
// Depends on wsd_pkg.
module wsd_outbuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  wsd_pkg::result_t  push_word,
    output logic              space,
    output logic              m_tvalid,
    input  logic              m_tready,
    output wsd_pkg::result_t  m_word
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    wsd_pkg::result_t out_reg, out_next;
    wsd_pkg::result_t skid_reg, skid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_next       = push_word;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_next       = push_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign space    = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_word   = out_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    a_stalled_push_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result pushed into a stalled output was lost");

endmodule

>>> rtl/window_sum_threshold_detector.sv
// Sliding-window sum threshold detector, top level.
// Instantiates the chain of window cells and the output buffer; depends on wsd_pkg.
//
// The block accepts one snapshot word per clock cycle while the output buffer has space,
// and delivers its result, if any, from a registered output. The window is a chain of
// WINDOW_MAX cells: each accepted word enters at cell window_length-1 while all cells
// shift one place toward cell 0, so once the window has filled cell 0 holds the oldest
// snapshot of the window; the running sum takes one add per word, and one subtract too
// once full. A two-entry output buffer lets the input keep flowing while one result
// waits. Writing window_length restarts the window; results resume once it has refilled.
module window_sum_threshold_detector #(
    parameter int WINDOW_MAX = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // object_count[15:0], day_code[31:16], start_time[48:32], end_time[65:49]
    input  logic [wsd_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // window_day[15:0], window_start[32:16], window_end[49:33], window_sum[69:50]
    output logic [wsd_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [wsd_pkg::IDX_REG_W-1:0]   cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int CNT_W  = (COUNT_BITS < wsd_pkg::FCNT_W) ? COUNT_BITS : wsd_pkg::FCNT_W;
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W  = CNT_W + LEN_W;
    localparam int CMP_W  = (SUM_W > wsd_pkg::WSUM_W) ? SUM_W : wsd_pkg::WSUM_W;

    logic [LEN_W-1:0]          len_reg, len_next;
    logic [wsd_pkg::WSUM_W-1:0] thr_reg, thr_next;
    logic [LEN_W-1:0]          fill_reg, fill_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;

    logic                      accept;
    logic                      space;
    logic [IDX_W-1:0]          last_idx;
    logic                      fill_ge;
    logic                      full_next;
    logic [SUM_W-1:0]          new_sum;
    logic [CMP_W-1:0]          sum_ext;
    logic [CMP_W-1:0]          thr_ext;
    logic                      push;
    logic [wsd_pkg::WLEN_W-1:0] wl_raw;
    logic [LEN_W-1:0]          wl_eff;

    logic [CNT_W-1:0]          in_cnt;
    wsd_pkg::tag_t             in_tag;
    logic [wsd_pkg::TIME_W-1:0] in_end;

    logic [CNT_W-1:0]          cell_cnt_q [WINDOW_MAX];
    wsd_pkg::tag_t             cell_tag_q [WINDOW_MAX];
    wsd_pkg::tag_t             cell_tag_d [WINDOW_MAX];

    wsd_pkg::result_t          res_word;
    wsd_pkg::result_t          out_word;

    assign in_cnt            = s_tdata[CNT_W-1:0];
    assign in_tag.day_code   = s_tdata[31:16];
    assign in_tag.start_time = s_tdata[48:32];
    assign in_end            = s_tdata[65:49];

    assign s_tready = space;
    assign accept   = s_tvalid && s_tready;
    assign last_idx = IDX_W'(len_reg - 1'b1);

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            logic [CNT_W-1:0] nbr_cnt;
            wsd_pkg::tag_t    nbr_tag;
            if (gi == WINDOW_MAX - 1) begin : g_end
                assign nbr_cnt = in_cnt;
                assign nbr_tag = in_tag;
            end else begin : g_mid
                assign nbr_cnt = cell_cnt_q[gi+1];
                assign nbr_tag = cell_tag_q[gi+1];
            end
            wsd_cell #(
                .CNT_W(CNT_W)
            ) u_cell (
                .aclk    (aclk),
                .load    (accept),
                .sel_new (last_idx == IDX_W'(gi)),
                .new_cnt (in_cnt),
                .new_tag (in_tag),
                .nbr_cnt (nbr_cnt),
                .nbr_tag (nbr_tag),
                .cnt_q   (cell_cnt_q[gi]),
                .tag_q   (cell_tag_q[gi]),
                .tag_d   (cell_tag_d[gi])
            );
        end
    endgenerate

    always_comb begin
        fill_ge   = (fill_reg >= len_reg);
        full_next = fill_ge || (LEN_W'(fill_reg + 1'b1) == len_reg);
        if (fill_ge) begin
            new_sum = sum_reg - SUM_W'(cell_cnt_q[0]) + SUM_W'(in_cnt);
        end else begin
            new_sum = sum_reg + SUM_W'(in_cnt);
        end
        sum_ext = CMP_W'(new_sum);
        thr_ext = CMP_W'(thr_reg);
        push    = accept && full_next && (sum_ext >= thr_ext);

        res_word.window_day   = cell_tag_d[0].day_code;
        res_word.window_start = cell_tag_d[0].start_time;
        res_word.window_end   = in_end;
        res_word.window_sum   = sum_ext[wsd_pkg::WSUM_W-1:0];
    end

    always_comb begin
        wl_raw = cfg_wdata[wsd_pkg::WLEN_W-1:0];
        if (32'(wl_raw) > 32'(WINDOW_MAX)) begin
            wl_eff = LEN_W'(WINDOW_MAX);
        end else if (wl_raw == '0) begin
            wl_eff = LEN_W'(1);
        end else begin
            wl_eff = LEN_W'(wl_raw);
        end
    end

    always_comb begin
        len_next  = len_reg;
        thr_next  = thr_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (accept) begin
            fill_next = fill_ge ? len_reg : LEN_W'(fill_reg + 1'b1);
            sum_next  = new_sum;
        end
        if (cfg_we) begin
            unique case (cfg_index)
                wsd_pkg::REG_WINDOW_LENGTH: begin
                    len_next  = wl_eff;
                    fill_next = '0;
                    sum_next  = '0;
                end
                wsd_pkg::REG_THRESHOLD: begin
                    thr_next = cfg_wdata[wsd_pkg::WSUM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= LEN_W'(1);
            thr_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end else begin
            len_reg  <= len_next;
            thr_reg  <= thr_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    wsd_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (res_word),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_word    (out_word)
    );

    assign m_tdata = {2'b00, out_word.window_sum, out_word.window_end,
                      out_word.window_start, out_word.window_day};

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= len_reg)
        else $error("fill level exceeds window length");

    a_len_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg != '0) && (32'(len_reg) <= 32'(WINDOW_MAX)))
        else $error("effective window length out of range");

    a_restart_on_len_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_we && cfg_index == wsd_pkg::REG_WINDOW_LENGTH) |=>
        (fill_reg == '0 && sum_reg == '0))
        else $error("window not restarted after length write");

    a_no_result_while_filling: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !fill_ge && LEN_W'(fill_reg + 1'b1) != len_reg) |-> !push)
        else $error("result produced before window filled");

endmodule

>>> bench/window_alert_checker.sv
// Checker for the window sum threshold detector: tracks the window from the observed
// configuration writes and accepted snapshot words, and compares every result word.
// Depends on wsd_pkg only.
module window_alert_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [wsd_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [wsd_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_we,
    input  logic [wsd_pkg::IDX_REG_W-1:0] cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            fail_count,
    output int                            pending_results
);
    import wsd_pkg::*;

    localparam int HIST_DEPTH = 16;

    typedef struct packed {
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] start_time;
        logic [DAY_W-1:0]  day_code;
        logic [FCNT_W-1:0] object_count;
    } snapshot_t;

    logic [FCNT_W-1:0] count_hist [HIST_DEPTH];
    logic [TIME_W-1:0] start_hist [HIST_DEPTH];
    logic [DAY_W-1:0]  day_hist   [HIST_DEPTH];
    logic [WSUM_W:0]   window_total;
    int                filled;
    logic [3:0]        head;
    logic [WLEN_W-1:0] length_reg;
    logic [WSUM_W-1:0] threshold_reg;
    result_t           expected_alerts [$];
    int                mismatches = 0;

    function automatic bit slide_window(input snapshot_t snap, output result_t alert);
        int         span;
        logic [3:0] leave_idx;
        logic [3:0] oldest_idx;
        span = (length_reg == 0) ? 1 :
               (length_reg > HIST_DEPTH) ? HIST_DEPTH : int'(length_reg);
        alert = '0;
        if (filled >= span) begin
            leave_idx = head - 4'(span);
            window_total = window_total - count_hist[leave_idx] + snap.object_count;
        end else begin
            window_total = window_total + snap.object_count;
            filled++;
        end
        count_hist[head] = snap.object_count;
        start_hist[head] = snap.start_time;
        day_hist[head]   = snap.day_code;
        oldest_idx = head + 4'd1 - 4'(span);
        head = head + 4'd1;
        if (filled < span || window_total < threshold_reg) return 1'b0;
        alert.window_day   = day_hist[oldest_idx];
        alert.window_start = start_hist[oldest_idx];
        alert.window_end   = snap.end_time;
        alert.window_sum   = window_total[WSUM_W-1:0];
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input logic [WSUM_W-1:0] want,
                               input logic [WSUM_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t   got;
        result_t   want;
        result_t   alert;
        snapshot_t snap;
        if (!aresetn) begin
            window_total  = '0;
            filled        = 0;
            head          = '0;
            length_reg    = 5'd1;
            threshold_reg = '0;
            expected_alerts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_alerts.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no result, got word %h", $time, got);
                end else begin
                    want = expected_alerts.pop_front();
                    check_field("window_day", want.window_day, got.window_day);
                    check_field("window_start", want.window_start, got.window_start);
                    check_field("window_end", want.window_end, got.window_end);
                    check_field("window_sum", want.window_sum, got.window_sum);
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_WINDOW_LENGTH) begin
                    length_reg   = cfg_wdata[WLEN_W-1:0];
                    window_total = '0;
                    filled       = 0;
                    head         = '0;
                end else if (cfg_index == REG_THRESHOLD) begin
                    threshold_reg = cfg_wdata[WSUM_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                snap = snapshot_t'(s_tdata[$bits(snapshot_t)-1:0]);
                if (slide_window(snap, alert)) begin
                    expected_alerts.insert(expected_alerts.size(), alert);
                end
            end
        end
        fail_count      <= mismatches;
        pending_results <= expected_alerts.size();
    end

endmodule

>>> bench/tb.sv
// Testbench top for the window sum threshold detector: drives snapshot words,
// register writes and output back-pressure, then reports the verdict.
// Depends on wsd_pkg, window_sum_threshold_detector and window_alert_checker.
module tb;
    import wsd_pkg::*;

    localparam int MAX_IDLE    = 17;
    localparam int SETTLE      = 8;
    localparam int DRAIN_LIMIT = 5000;
    localparam int RANDOM_GOAL = 1350;
    localparam int LONG_HOLD   = 80;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [IDX_REG_W-1:0] cfg_index = REG_WINDOW_LENGTH;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    int                   fail_count;
    int                   pending_results;
    int                   span_now         = 1;
    bit                   sender_idles     = 1'b0;
    bit                   receiver_idles   = 1'b0;
    bit                   hold_off_request = 1'b0;

    always #5 aclk = ~aclk;

    window_sum_threshold_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    window_alert_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    task automatic offer_snapshot(input logic [FCNT_W-1:0] count,
                                  input logic [DAY_W-1:0]  day,
                                  input logic [TIME_W-1:0] t_start,
                                  input logic [TIME_W-1:0] t_end);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_DATA_W'({t_end, t_start, day, count});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [IDX_REG_W-1:0] index, input logic [CFG_W-1:0] word);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= word;
        @(posedge aclk);
        if (index == REG_WINDOW_LENGTH) begin
            span_now = (word[WLEN_W-1:0] == 0) ? 1 :
                       (word[WLEN_W-1:0] > 16) ? 16 : int'(word[WLEN_W-1:0]);
        end
    endtask

    task automatic drain_results();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (pending_results != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [FCNT_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return FCNT_W'($urandom_range(0, 255));
            default: return FCNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time(input int top);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TIME_W'(top);
            2:       return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_length();
        logic [CFG_W-1:0] word;
        word = CFG_W'($urandom);
        if ($urandom_range(0, 1)) word[CFG_W-1:WLEN_W] = '0;
        case ($urandom_range(0, 7))
            0:       word[WLEN_W-1:0] = 5'd0;
            1:       word[WLEN_W-1:0] = 5'd1;
            2:       word[WLEN_W-1:0] = 5'd16;
            3:       word[WLEN_W-1:0] = 5'd31;
            default: word[WLEN_W-1:0] = WLEN_W'($urandom_range(1, 16));
        endcase
        return word;
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'(span_now * 32768);
            default: return CFG_W'($urandom_range(0, span_now * 65535));
        endcase
    endfunction

    initial begin : receiver
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_off_request) begin
                stall = LONG_HOLD;
                hold_off_request = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int phase;
        int sent;
        int items;
        int pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        receiver_idles = 1'b1;

        // After reset the window is one word long and the threshold is zero.
        offer_snapshot(16'h0000, 16'h0000, 17'd0, 17'd0);
        offer_snapshot(16'hFFFF, 16'hFFFF, 17'd86399, 17'd86400);
        offer_snapshot(16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF);
        offer_snapshot(16'h0001, 16'hAAAA, 17'h15555, 17'h0AAAA);
        offer_snapshot(16'd12345, 16'h5555, 17'h0AAAA, 17'h15555);
        drain_results();

        // A length of zero acts as one; the threshold sits exactly on the first count.
        write_reg(REG_WINDOW_LENGTH, '0);
        write_reg(REG_THRESHOLD, CFG_W'(65535));
        cfg_we <= 1'b0;
        offer_snapshot(16'hFFFF, 16'h0102, 17'd100, 17'd200);
        offer_snapshot(16'hFFFE, 16'h0103, 17'd200, 17'd300);
        drain_results();

        // An oversized length saturates to the full window, which alerts only at its peak.
        write_reg(REG_WINDOW_LENGTH, CFG_W'(31));
        write_reg(REG_THRESHOLD, CFG_W'(1048560));
        cfg_we <= 1'b0;
        for (int i = 0; i < 17; i++)
            offer_snapshot('1, DAY_W'(i + 7), TIME_W'(i * 100), TIME_W'(i * 100 + 99));
        drain_results();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_GOAL) begin
            sender_idles   = $urandom_range(0, 2) != 0;
            receiver_idles = $urandom_range(0, 2) != 0;
            items = $urandom_range(10, 80);
            if (phase == 3) begin
                // Every word alerts while the receiver holds off, so the input backs up.
                sender_idles = 1'b0;
                write_reg(REG_WINDOW_LENGTH, CFG_W'(1));
                write_reg(REG_THRESHOLD, '0);
                hold_off_request = 1'b1;
                items = 40;
            end else begin
                pick = $urandom_range(0, 3);
                if (pick != 1) write_reg(REG_WINDOW_LENGTH, pick_length());
                if (pick != 0) write_reg(REG_THRESHOLD, pick_threshold());
            end
            cfg_we <= 1'b0;
            for (int k = 0; k < items; k++)
                offer_snapshot(pick_count(), DAY_W'($urandom), pick_time(86399),
                               pick_time(86400));
            drain_results();
            sent += items;
            phase++;
        end

        if (fail_count == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/wsd_pkg.sv
rtl/wsd_cell.sv
rtl/wsd_outbuf.sv
rtl/window_sum_threshold_detector.sv
bench/window_alert_checker.sv
bench/tb.sv
